FILE: sv/assert_macros.svh
// Assertion helpers: an implication in the same cycle and one into the next cycle.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cbs assertion failed");
`define CBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cbs assertion failed");
`else
`define CBS_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define CBS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/cbs_pkg.sv
package cbs_pkg;

    localparam int TABLE_DEPTH = 32;

    localparam int FRAC_BITS  = 12;
    localparam int IDX_W      = 5;
    localparam int POINT_W    = 16;
    localparam int POS_W      = 16;
    localparam int RESULT_W   = 10;
    localparam int SEG_W      = POS_W - FRAC_BITS;
    // Only the low bits of the running sum reach the result.
    localparam int ACC_W      = FRAC_BITS + RESULT_W;
    localparam int END_W      = 20;

    localparam logic [FRAC_BITS-1:0] FRAC_MASK  = 12'd4095;
    localparam logic [FRAC_BITS-1:0] MID_A      = 12'h0AAA;
    localparam logic [FRAC_BITS-1:0] MID_B      = 12'h02AA;
    localparam logic [7:0]           END_WEIGHT = 8'd171;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } t_op;

    // Blending weights, end weights already scaled by 171
    typedef struct packed {
        logic [END_W-1:0]     w0k;
        logic [FRAC_BITS-1:0] w1;
        logic [FRAC_BITS:0]   w2;
        logic [END_W-1:0]     t3k;
    } t_weights;

endpackage

FILE: sv/cbs_in_if.sv
interface cbs_in_if;
    logic                                  valid;
    logic                                  ready;
    cbs_pkg::t_op                          op;
    logic [cbs_pkg::IDX_W-1:0]             point_index;
    logic signed [cbs_pkg::POINT_W-1:0]    point_value;
    logic [cbs_pkg::POS_W-1:0]             position;

    modport source (output valid, op, point_index, point_value, position, input ready);
    modport sink   (input valid, op, point_index, point_value, position, output ready);
endinterface

FILE: sv/cbs_out_if.sv
interface cbs_out_if;
    logic                             valid;
    logic                             ready;
    logic [cbs_pkg::RESULT_W-1:0]     spline_value;

    modport source (output valid, spline_value, input ready);
    modport sink   (input valid, spline_value, output ready);
endinterface

FILE: sv/cbs_weights.sv
// Three-stage weight pipeline; outputs come from the third stage's registers.
module cbs_weights (
    input  logic                              i_clk,
    input  logic [cbs_pkg::FRAC_BITS-1:0]     i_frac,
    output cbs_pkg::t_weights                 o_weights
);

    localparam int FB = cbs_pkg::FRAC_BITS;

    logic [FB-1:0]   u;
    logic [2*FB-1:0] uu_full;
    logic [2*FB-1:0] tt_full;
    logic [2*FB-1:0] w0_full;
    logic [2*FB-1:0] t2t_full;
    logic [FB+1:0]   w1_sum;
    logic [FB:0]     w2_sum;

    logic [FB-1:0]   r_uu;
    logic [FB-1:0]   r_t2;
    logic [FB-1:0]   r_w0;
    logic [FB-1:0]   r_t3;
    logic [FB-2:0]   r_t2t13;
    cbs_pkg::t_weights r_w;

    assign u        = cbs_pkg::FRAC_MASK - i_frac;
    assign uu_full  = u * u;
    assign tt_full  = i_frac * i_frac;
    assign w0_full  = u * r_uu;
    assign t2t_full = r_t2 * i_frac;

    // Middle weights stay positive, so the narrow sums never wrap.
    assign w1_sum = {3'b000, r_t2t13} - {2'b00, r_t2} + {2'b00, cbs_pkg::MID_A};
    assign w2_sum = {1'b0, i_frac} + {1'b0, r_t2} - {1'b0, r_t3};

    always_ff @(posedge i_clk) begin
        r_uu    <= uu_full[2*FB-1:FB];
        r_t2    <= tt_full[2*FB-1:FB];
        r_w0    <= w0_full[2*FB-1:FB];
        r_t3    <= t2t_full[2*FB-1:FB];
        r_t2t13 <= t2t_full[2*FB-1:FB+1];
        r_w.w0k <= cbs_pkg::END_W'(r_w0) * cbs_pkg::END_W'(cbs_pkg::END_WEIGHT);
        r_w.t3k <= cbs_pkg::END_W'(r_t3) * cbs_pkg::END_W'(cbs_pkg::END_WEIGHT);
        r_w.w1  <= w1_sum[FB-1:0];
        r_w.w2  <= {1'b0, w2_sum[FB:1]} + {1'b0, cbs_pkg::MID_B};
    end

    assign o_weights = r_w;

endmodule

FILE: sv/cubic_bspline_table_eval.sv
// Load item: writes one table entry, gives no result.
// Evaluate item: result registered out of the last phase once the output register is
// free; no new item is taken until idle again, the sequence being set by the four reads
// through the single table port and the three-stage weight chain ahead of the product.
// Reset (synchronous, active low) clears control state; the table is undefined
// until written and gets no clearing pass.
module cubic_bspline_table_eval #(
    parameter int TABLE_DEPTH = cbs_pkg::TABLE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    cbs_in_if.sink       i_in,
    cbs_out_if.source    o_out
);

    `include "assert_macros.svh"

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int ACC_W = cbs_pkg::ACC_W;
    localparam int FB    = cbs_pkg::FRAC_BITS;
    localparam int PW    = cbs_pkg::POINT_W;

    // Phase plan inside one evaluation:
    //   0..2 weights settle in cbs_weights
    //   2..5 read entries seg..seg+3, one per phase
    //   3..6 multiply the entry read last phase by its weight
    //   4..7 accumulate; phase 7 adds the last term and loads the result
    localparam logic [2:0] PH_FIRST_RD   = 3'd2;
    localparam logic [2:0] PH_LAST_RD    = 3'd5;
    localparam logic [2:0] PH_FIRST_MUL  = 3'd3;
    localparam logic [2:0] PH_LAST_MUL   = 3'd6;
    localparam logic [2:0] PH_END0_ACC  = 3'd4;
    localparam logic [2:0] PH_MID1_MUL   = 3'd4;
    localparam logic [2:0] PH_MID2_MUL   = 3'd5;
    localparam logic [2:0] PH_LAST       = 3'd7;

    typedef enum logic {
        ST_IDLE,
        ST_BUSY
    } t_state;

    // Control and registered outputs
    t_state                         r_state;
    logic [2:0]                     r_ph;
    logic                           r_out_valid;
    logic [cbs_pkg::RESULT_W-1:0]   r_out_value;

    // Datapath
    logic signed [PW-1:0]           r_mem [TABLE_DEPTH];
    logic [FB-1:0]                  r_t;
    logic [cbs_pkg::SEG_W-1:0]      r_seg;
    logic signed [PW-1:0]           r_pt;
    logic [31:0]                    r_prod;
    logic [ACC_W-1:0]               r_acc;

    cbs_pkg::t_weights              weights;
    logic                           in_acc;
    logic                           eval_acc;
    logic                           load_acc;
    logic                           busy;
    logic                           rd_en;
    logic                           mul_en;
    logic                           acc_en;
    logic                           finish;
    logic [1:0]                     rd_off;
    logic [cbs_pkg::SEG_W:0]        rd_idx;
    logic [cbs_pkg::END_W-1:0]      wsel;
    logic signed [PW+cbs_pkg::END_W:0] prod;
    logic [ACC_W-1:0]               term;
    logic [ACC_W-1:0]               n_sum;

    assign busy     = (r_state == ST_BUSY);
    assign in_acc   = i_in.valid && i_in.ready;
    assign eval_acc = in_acc && (i_in.op == cbs_pkg::OP_EVAL);
    assign load_acc = in_acc && (i_in.op == cbs_pkg::OP_LOAD)
                      && (int'(i_in.point_index) < TABLE_DEPTH);

    assign rd_en  = busy && (r_ph >= PH_FIRST_RD) && (r_ph <= PH_LAST_RD);
    assign mul_en = busy && (r_ph >= PH_FIRST_MUL) && (r_ph <= PH_LAST_MUL);
    assign acc_en = busy && (r_ph >= PH_END0_ACC) && (r_ph < PH_LAST);
    assign finish = busy && (r_ph == PH_LAST) && (!r_out_valid || o_out.ready);

    assign rd_off = 2'(r_ph - PH_FIRST_RD);
    assign rd_idx = {1'b0, r_seg} + {3'b000, rd_off};

    cbs_weights u_weights (
        .i_clk     (i_clk),
        .i_frac    (r_t),
        .o_weights (weights)
    );

    // Pick the weight that matches the entry now in r_pt
    always_comb begin
        case (r_ph)
            PH_FIRST_MUL: wsel = weights.w0k;
            PH_MID1_MUL:  wsel = cbs_pkg::END_W'(weights.w1);
            PH_MID2_MUL:  wsel = cbs_pkg::END_W'(weights.w2);
            default:      wsel = weights.t3k;
        endcase
    end

    assign prod = r_pt * $signed({1'b0, wsel});

    // End terms take bits 31..10 of the wrapped product (arithmetic shift by
    // ten); middle terms enter unshifted. Only the low ACC_W bits matter.
    assign term  = ((r_ph == PH_END0_ACC) || (r_ph == PH_LAST)) ?
                   r_prod[31:10] : r_prod[ACC_W-1:0];
    assign n_sum = r_acc + term;

    // Table: written only on an accepted load in idle, read only while busy,
    // so the two never touch the same cycle.
    always_ff @(posedge i_clk) begin
        if (load_acc) begin
            r_mem[AW'(i_in.point_index)] <= i_in.point_value;
        end
        if (rd_en) begin
            r_pt <= r_mem[AW'(rd_idx)];
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (eval_acc) begin
            r_t   <= i_in.position[FB-1:0];
            r_seg <= i_in.position[cbs_pkg::POS_W-1:FB];
            r_acc <= '0;
        end else if (acc_en) begin
            r_acc <= n_sum;
        end
        if (mul_en) begin
            r_prod <= prod[31:0];
        end
    end

    // Sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_ph        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            case (r_state)
                ST_IDLE: begin
                    if (eval_acc) begin
                        r_state <= ST_BUSY;
                        r_ph    <= '0;
                    end
                end
                ST_BUSY: begin
                    if (r_ph != PH_LAST) begin
                        r_ph <= r_ph + 3'd1;
                    end else if (finish) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase

            // Hold the result until taken; reload in the cycle it leaves
            if (finish) begin
                r_out_valid <= 1'b1;
                r_out_value <= n_sum[ACC_W-1:FB];
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign i_in.ready         = (r_state == ST_IDLE);
    assign o_out.valid        = r_out_valid;
    assign o_out.spline_value = r_out_value;

    // An accepted evaluate starts the sequence at phase zero
    `CBS_ASSERT_NEXT(a_eval_starts, i_clk, i_rst_n, eval_acc, busy && r_ph == 3'd0)
    // Phases advance by one each cycle until the last
    `CBS_ASSERT_NEXT(a_phase_steps, i_clk, i_rst_n, busy && r_ph != PH_LAST, busy && r_ph == $past(r_ph) + 3'd1)
    // A result appears only out of the last phase
    `CBS_ASSERT_SAME(a_result_src, i_clk, i_rst_n, $rose(r_out_valid), $past(busy && r_ph == PH_LAST))
    // A load never starts the sequencer
    `CBS_ASSERT_NEXT(a_load_idle, i_clk, i_rst_n, in_acc && i_in.op == cbs_pkg::OP_LOAD, !busy)

endmodule
